@@ src/lsms_pkg.sv @@
// shared types, codes and reset constants for the lead screw move sequencer
package lsms_pkg;

  // field widths
  localparam int ActionW = 3;
  localparam int SeqW    = 8;
  localparam int PosW    = 32;
  localparam int TimeW   = 32;
  localparam int CodeW   = 8;
  localparam int TolW    = 16;
  localparam int MotorW  = 3;
  localparam int KindW   = 2;
  localparam int FlagW   = 8;
  localparam int ModeW   = 3;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 2;

  // register reset values
  localparam logic [TolW-1:0]  TolReset     = 16'd2;
  localparam logic [TimeW-1:0] TimeoutReset = 32'd10000;
  localparam logic [TolW-1:0]  MinProgReset = 16'd5;
  localparam logic [TimeW-1:0] StallReset   = 32'd500;

  // fault flags
  localparam logic [FlagW-1:0] FlagTimeout = 8'h01;
  localparam logic [FlagW-1:0] FlagStall   = 8'h02;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TOLERANCE = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_MIN_PROG  = 2'd2,
    REG_STALL     = 2'd3
  } reg_idx_t;

  typedef enum logic [ModeW-1:0] {
    MODE_IDLE     = 3'd0,
    MODE_HOMING   = 3'd1,
    MODE_MOVING   = 3'd2,
    MODE_TRACKING = 3'd3,
    MODE_FAULT    = 3'd4
  } mode_t;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK        = 3'd0,
    ACT_HOME        = 3'd1,
    ACT_MOVE_REL    = 3'd2,
    ACT_TRACK_START = 3'd3,
    ACT_TRACK_STOP  = 3'd4,
    ACT_STOP        = 3'd5,
    ACT_CLEAR_FAULT = 3'd6
  } action_t;

  typedef enum logic [MotorW-1:0] {
    MOTOR_NONE  = 3'd0,
    MOTOR_STOP  = 3'd1,
    MOTOR_UP    = 3'd2,
    MOTOR_DOWN  = 3'd3,
    MOTOR_TRACK = 3'd4
  } motor_t;

  typedef enum logic [KindW-1:0] {
    KIND_HOME_DONE = 2'd0,
    KIND_MOVE_DONE = 2'd1,
    KIND_FAULT     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [TolW-1:0]  tolerance;
    logic [TimeW-1:0] timeout_ms;
    logic [TolW-1:0]  min_progress;
    logic [TimeW-1:0] stall_ms;
  } cfg_t;

  typedef struct packed {
    logic [ActionW-1:0]    action;
    logic [SeqW-1:0]       sequence_req;
    logic signed [PosW-1:0] movement;
    logic signed [PosW-1:0] position;
    logic [TimeW-1:0]      time_ms;
    logic                  homing_ok;
    logic [CodeW-1:0]      homing_code;
  } in_item_t;

  typedef struct packed {
    logic                   accepted;
    logic [MotorW-1:0]      motor_cmd;
    logic                   packet_valid;
    logic [KindW-1:0]       packet_kind;
    logic [SeqW-1:0]        packet_sequence;
    logic signed [PosW-1:0] packet_position;
    logic [FlagW-1:0]       packet_flags;
    logic [ModeW-1:0]       mode;
  } out_item_t;

endpackage

@@ src/lead_screw_move_sequencer.sv @@
// top level of the lead screw move sequencer
//
//  channel  | signals                       | moves
//  ---------+-------------------------------+---------------------------------
//  in       | in_valid / in_ready           | one request or tick item
//  out      | out_valid / out_ready         | one result item per input item
//  cfg      | cfg_we, cfg_index, cfg_data   | register write, no handshake
//
// an item passes from the input register to the result register before it
// is shown; one item per cycle is sustained while out_ready stays high,
// with the mode state updated as each item moves between the two registers.
// rst is synchronous and returns mode to idle and the registers to defaults.
// a stalled result holds the result register; the input register takes one
// more item, then in_ready drops until the result is taken.
module lead_screw_move_sequencer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [lsms_pkg::ActionW-1:0]          action,
  input  logic [lsms_pkg::SeqW-1:0]             sequence_req,
  input  logic signed [lsms_pkg::PosW-1:0]      movement,
  input  logic signed [lsms_pkg::PosW-1:0]      position,
  input  logic [lsms_pkg::TimeW-1:0]            time_ms,
  input  logic                                  homing_ok,
  input  logic [lsms_pkg::CodeW-1:0]            homing_code,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  accepted,
  output logic [lsms_pkg::MotorW-1:0]           motor_cmd,
  output logic                                  packet_valid,
  output logic [lsms_pkg::KindW-1:0]            packet_kind,
  output logic [lsms_pkg::SeqW-1:0]             packet_sequence,
  output logic signed [lsms_pkg::PosW-1:0]      packet_position,
  output logic [lsms_pkg::FlagW-1:0]            packet_flags,
  output logic [lsms_pkg::ModeW-1:0]            mode,
  input  logic                                  cfg_we,
  input  logic [lsms_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [lsms_pkg::CfgDataW-1:0]         cfg_data
);
  import lsms_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item, held_item;
  out_item_t result, out_item;
  logic      held_valid, advance;

  // gather input fields
  always_comb begin
    in_item.action       = action;
    in_item.sequence_req = sequence_req;
    in_item.movement     = movement;
    in_item.position     = position;
    in_item.time_ms      = time_ms;
    in_item.homing_ok    = homing_ok;
    in_item.homing_code  = homing_code;
  end

  // held item moves on when the result register is free or being emptied
  assign advance = held_valid && (!out_valid || out_ready);

  lsms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsms_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .advance    (advance)
  );

  lsms_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (held_item),
    .result  (result)
  );

  lsms_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // spread result fields onto ports
  assign accepted        = out_item.accepted;
  assign motor_cmd       = out_item.motor_cmd;
  assign packet_valid    = out_item.packet_valid;
  assign packet_kind     = out_item.packet_kind;
  assign packet_sequence = out_item.packet_sequence;
  assign packet_position = out_item.packet_position;
  assign packet_flags    = out_item.packet_flags;
  assign mode            = out_item.mode;

endmodule

@@ src/lsms_cfg.sv @@
// configuration registers of the move sequencer
module lsms_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lsms_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [lsms_pkg::CfgDataW-1:0]   cfg_data,
  output lsms_pkg::cfg_t                  cfg
);
  import lsms_pkg::*;

  // register file, written by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance    <= TolReset;
      cfg.timeout_ms   <= TimeoutReset;
      cfg.min_progress <= MinProgReset;
      cfg.stall_ms     <= StallReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TOLERANCE: cfg.tolerance    <= cfg_data[TolW-1:0];
        REG_TIMEOUT:   cfg.timeout_ms   <= cfg_data[TimeW-1:0];
        REG_MIN_PROG:  cfg.min_progress <= cfg_data[TolW-1:0];
        REG_STALL:     cfg.stall_ms     <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/lsms_in_reg.sv @@
// input register stage holding one item
module lsms_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsms_pkg::in_item_t in_item,
  output logic               held_valid,
  output lsms_pkg::in_item_t held_item,
  input  logic               advance
);
  import lsms_pkg::*;

  // free when empty or when the held item moves on this cycle
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

@@ src/lsms_step.sv @@
// mode state and single-item step logic
module lsms_step (
  input  logic                clk,
  input  logic                rst,
  input  lsms_pkg::cfg_t      cfg,
  input  logic                advance,
  input  lsms_pkg::in_item_t  item,
  output lsms_pkg::out_item_t result
);
  import lsms_pkg::*;

  localparam int RemW  = PosW + 2;
  localparam int DiffW = PosW + 1;

  mode_t                  mode_reg, mode_reg_next;
  logic [SeqW-1:0]        active_seq, active_seq_next;
  logic [PosW-1:0]        pending_move, pending_move_next;
  logic                   target_latched, target_latched_next;
  logic [DiffW-1:0]       target_pos, target_pos_next;
  logic [TimeW-1:0]       start_time, start_time_next;
  logic [PosW-1:0]        progress_pos, progress_pos_next;
  logic [TimeW-1:0]       progress_time, progress_time_next;

  logic [RemW-1:0]        rem, rem_abs;
  logic [DiffW-1:0]       dprog, dprog_abs;
  logic [TimeW-1:0]       start_ref, prog_time_ref, elapsed, idle_time;
  logic [PosW-1:0]        prog_pos_ref;
  logic                   pv;
  kind_t                  kind;
  motor_t                 motor;
  logic [FlagW-1:0]       flags;
  logic                   acc;

  // move arithmetic; on the first tick the references are this tick itself
  always_comb begin
    if (target_latched) begin
      rem = {target_pos[DiffW-1], target_pos} - {{2{item.position[PosW-1]}}, item.position};
    end else begin
      rem = {{2{pending_move[PosW-1]}}, pending_move};
    end
    rem_abs       = rem[RemW-1] ? (~rem + 1'b1) : rem;
    start_ref     = target_latched ? start_time : item.time_ms;
    prog_time_ref = target_latched ? progress_time : item.time_ms;
    prog_pos_ref  = target_latched ? progress_pos : item.position;
    elapsed       = item.time_ms - start_ref;
    idle_time     = item.time_ms - prog_time_ref;
    dprog         = {item.position[PosW-1], item.position}
                  - {prog_pos_ref[PosW-1], prog_pos_ref};
    dprog_abs     = dprog[DiffW-1] ? (~dprog + 1'b1) : dprog;
  end

  // next state and result for the held item
  always_comb begin
    mode_reg_next       = mode_reg;
    active_seq_next     = active_seq;
    pending_move_next   = pending_move;
    target_latched_next = target_latched;
    target_pos_next     = target_pos;
    start_time_next     = start_time;
    progress_pos_next   = progress_pos;
    progress_time_next  = progress_time;
    acc   = 1'b0;
    motor = MOTOR_NONE;
    pv    = 1'b0;
    kind  = KIND_HOME_DONE;
    flags = '0;

    unique case (action_t'(item.action))
      ACT_TICK: begin
        unique case (mode_reg)
          MODE_IDLE, MODE_FAULT: motor = MOTOR_STOP;
          MODE_TRACKING:         motor = MOTOR_TRACK;
          MODE_HOMING: begin
            pv = 1'b1;
            if (item.homing_ok) begin
              mode_reg_next = MODE_IDLE;
              kind  = KIND_HOME_DONE;
              flags = FlagW'(MODE_IDLE);
            end else begin
              mode_reg_next = MODE_FAULT;
              kind  = KIND_FAULT;
              flags = item.homing_code;
            end
          end
          MODE_MOVING: begin
            // latch target and references on the first tick of the move
            if (!target_latched) begin
              target_pos_next = {item.position[PosW-1], item.position}
                              + {pending_move[PosW-1], pending_move};
              start_time_next     = item.time_ms;
              progress_time_next  = item.time_ms;
              progress_pos_next   = item.position;
              target_latched_next = 1'b1;
            end
            if (rem_abs <= RemW'(cfg.tolerance)) begin
              motor = MOTOR_STOP; pv = 1'b1; kind = KIND_MOVE_DONE;
              flags = FlagW'(MODE_IDLE);
              target_latched_next = 1'b0;
              mode_reg_next = MODE_IDLE;
            end else if (elapsed >= cfg.timeout_ms) begin
              motor = MOTOR_STOP; pv = 1'b1; kind = KIND_FAULT;
              flags = FlagTimeout;
              target_latched_next = 1'b0;
              mode_reg_next = MODE_FAULT;
            end else if (dprog_abs >= DiffW'(cfg.min_progress)) begin
              progress_pos_next  = item.position;
              progress_time_next = item.time_ms;
              motor = (!rem[RemW-1] && (rem != '0)) ? MOTOR_UP : MOTOR_DOWN;
            end else if (idle_time >= cfg.stall_ms) begin
              motor = MOTOR_STOP; pv = 1'b1; kind = KIND_FAULT;
              flags = FlagStall;
              target_latched_next = 1'b0;
              mode_reg_next = MODE_FAULT;
            end else begin
              motor = (!rem[RemW-1] && (rem != '0)) ? MOTOR_UP : MOTOR_DOWN;
            end
          end
          default: ;
        endcase
      end
      ACT_HOME, ACT_MOVE_REL, ACT_TRACK_START: begin
        if (mode_reg == MODE_IDLE) begin
          acc = 1'b1;
          active_seq_next = item.sequence_req;
          if (action_t'(item.action) == ACT_HOME) begin
            mode_reg_next = MODE_HOMING;
          end else if (action_t'(item.action) == ACT_MOVE_REL) begin
            pending_move_next   = item.movement;
            target_latched_next = 1'b0;
            mode_reg_next       = MODE_MOVING;
          end else begin
            mode_reg_next = MODE_TRACKING;
          end
        end
      end
      ACT_TRACK_STOP: begin
        if (mode_reg == MODE_TRACKING) begin
          acc = 1'b1;
          active_seq_next = item.sequence_req;
          motor = MOTOR_STOP;
          mode_reg_next = MODE_IDLE;
        end
      end
      ACT_STOP: begin
        acc = 1'b1;
        motor = MOTOR_STOP;
        target_latched_next = 1'b0;
        mode_reg_next = MODE_IDLE;
      end
      ACT_CLEAR_FAULT: begin
        if (mode_reg == MODE_FAULT) begin
          acc = 1'b1;
          target_latched_next = 1'b0;
          mode_reg_next = MODE_IDLE;
        end
      end
      default: ;
    endcase

    // pack the result, packet fields zero without a packet
    result.accepted        = acc;
    result.motor_cmd       = motor;
    result.packet_valid    = pv;
    result.packet_kind     = pv ? kind : KIND_HOME_DONE;
    result.packet_sequence = pv ? active_seq_next : '0;
    result.packet_position = pv ? item.position : '0;
    result.packet_flags    = pv ? flags : '0;
    result.mode            = mode_reg_next;
  end

  // state registers, updated as each item leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_IDLE;
      active_seq     <= '0;
      pending_move   <= '0;
      target_latched <= 1'b0;
      target_pos     <= '0;
      start_time     <= '0;
      progress_pos   <= '0;
      progress_time  <= '0;
    end else if (advance) begin
      mode_reg       <= mode_reg_next;
      active_seq     <= active_seq_next;
      pending_move   <= pending_move_next;
      target_latched <= target_latched_next;
      target_pos     <= target_pos_next;
      start_time     <= start_time_next;
      progress_pos   <= progress_pos_next;
      progress_time  <= progress_time_next;
    end
  end

endmodule

@@ src/lsms_out_reg.sv @@
// result register stage
module lsms_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  lsms_pkg::out_item_t result,
  output logic                out_valid,
  input  logic                out_ready,
  output lsms_pkg::out_item_t out_item
);
  import lsms_pkg::*;

  // valid follows loads and clears once the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= result;
    end
  end

endmodule
